[rtl/core/pixel_convert_brightness_stats_core_defines.svh]
// Assertion macros shared by the pixel convert and statistics core.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef PIXEL_CONVERT_BRIGHTNESS_STATS_CORE_DEFINES_SVH
`define PIXEL_CONVERT_BRIGHTNESS_STATS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset
`define PCBS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset
`define PCBS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCBS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PCBS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/core/pcbs_pkg.sv]
// Package for the pixel convert and statistics core: widths, codes, types, helpers.
// No dependencies.
package pcbs_pkg;

   localparam int MAX_DIMENSION  = 4096;
   localparam int POS_WIDTH      = 12;
   localparam int DIM_WIDTH      = 13;
   localparam int TALLY_WIDTH    = 25;
   localparam int CHAN_WIDTH     = 8;
   localparam int RGB_WIDTH      = 24;
   localparam int WORD_WIDTH     = 32;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [TALLY_WIDTH-1:0] TALLY_MAX     = '1;
   localparam logic [POS_WIDTH-1:0]   EDGE_ONES     = '1;
   localparam logic [CHAN_WIDTH-1:0]  DIM_LIMIT     = 8'd32;
   localparam logic [CHAN_WIDTH-1:0]  BRIGHT_LIMIT  = 8'd128;
   localparam logic [DIM_WIDTH-1:0]   WIDTH_RESET   = 13'd640;
   localparam logic [DIM_WIDTH-1:0]   HEIGHT_RESET  = 13'd480;

   typedef enum logic [1:0] {
      CLASS_ZERO,
      CLASS_DIM,
      CLASS_MID,
      CLASS_BRIGHT
   } pixel_class_type;

   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic {
      FMT_ARGB8888 = 1'b0,
      FMT_RGB565   = 1'b1
   } pixel_format_type;

   typedef struct packed {
      logic [RGB_WIDTH-1:0]  rgb;
      logic [CHAN_WIDTH-1:0] peak;
      pixel_class_type       pclass;
   } pixel_info_type;

   typedef struct packed {
      logic                   frame_done;
      logic [TALLY_WIDTH-1:0] zero_count;
      logic [TALLY_WIDTH-1:0] dim_count;
      logic [TALLY_WIDTH-1:0] mid_count;
      logic [TALLY_WIDTH-1:0] bright_count;
      logic [CHAN_WIDTH-1:0]  peak_channel;
      logic                   any_nonzero;
      logic [POS_WIDTH-1:0]   box_left;
      logic [POS_WIDTH-1:0]   box_top;
      logic [POS_WIDTH-1:0]   box_right;
      logic [POS_WIDTH-1:0]   box_bottom;
   } frame_stats_type;

   // Last valid position for a programmed dimension: zero acts as one, large values clamp
   function automatic logic [POS_WIDTH-1:0] limit_last(input logic [DIM_WIDTH-1:0] dim);
      logic [DIM_WIDTH-1:0] less_one;
      less_one = dim - 13'd1;
      if (dim == '0) begin
         return '0;
      end else if (dim > DIM_WIDTH'(MAX_DIMENSION)) begin
         return POS_WIDTH'(MAX_DIMENSION - 1);
      end else begin
         return less_one[POS_WIDTH-1:0];
      end
   endfunction

   // Saturating tally increment
   function automatic logic [TALLY_WIDTH-1:0] sat_bump(input logic [TALLY_WIDTH-1:0] tally,
                                                      input logic hit);
      if (hit && (tally != TALLY_MAX)) begin
         return tally + 25'd1;
      end else begin
         return tally;
      end
   endfunction

endpackage

[rtl/core/pcbs_convert.sv]
// Pixel conversion to RGB888, largest channel and brightness class.
// Depends on pcbs_pkg.
module pcbs_convert
   import pcbs_pkg::*;
(
   input  logic                  pixel_format,
   input  logic [WORD_WIDTH-1:0] pixel_word,
   output pixel_info_type        info
);

   logic [CHAN_WIDTH-1:0] red;
   logic [CHAN_WIDTH-1:0] green;
   logic [CHAN_WIDTH-1:0] blue;
   logic [CHAN_WIDTH-1:0] largest;

   // Unpack the word; RGB565 widens by repeating the top bits
   always_comb begin
      unique case (pixel_format_type'(pixel_format))
         FMT_RGB565: begin
            red   = {pixel_word[15:11], pixel_word[15:13]};
            green = {pixel_word[10:5],  pixel_word[10:9]};
            blue  = {pixel_word[4:0],   pixel_word[4:2]};
         end
         default: begin
            red   = pixel_word[23:16];
            green = pixel_word[15:8];
            blue  = pixel_word[7:0];
         end
      endcase
   end

   // Find the largest channel
   always_comb begin
      largest = red;
      if (green > largest) begin
         largest = green;
      end
      if (blue > largest) begin
         largest = blue;
      end
   end

   // Class the pixel by its largest channel
   always_comb begin
      info.rgb  = {red, green, blue};
      info.peak = largest;
      priority if (largest == '0) begin
         info.pclass = CLASS_ZERO;
      end else if (largest < DIM_LIMIT) begin
         info.pclass = CLASS_DIM;
      end else if (largest < BRIGHT_LIMIT) begin
         info.pclass = CLASS_MID;
      end else begin
         info.pclass = CLASS_BRIGHT;
      end
   end

endmodule

[rtl/core/pcbs_stats.sv]
// Frame statistics: raster position, class tallies, peak channel and bounding box.
// Depends on pcbs_pkg.
module pcbs_stats
   import pcbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  pixel_info_type       info,
   input  logic [DIM_WIDTH-1:0] frame_width,
   input  logic [DIM_WIDTH-1:0] frame_height,
   output frame_stats_type      result
);

   logic [POS_WIDTH-1:0]   column_ff, column_in;
   logic [POS_WIDTH-1:0]   row_ff, row_in;
   logic [TALLY_WIDTH-1:0] zero_ff, zero_in;
   logic [TALLY_WIDTH-1:0] dim_ff, dim_in;
   logic [TALLY_WIDTH-1:0] mid_ff, mid_in;
   logic [TALLY_WIDTH-1:0] bright_ff, bright_in;
   logic [CHAN_WIDTH-1:0]  peak_ff, peak_in;
   logic                   seen_ff, seen_in;
   logic [POS_WIDTH-1:0]   left_ff, left_in;
   logic [POS_WIDTH-1:0]   top_ff, top_in;
   logic [POS_WIDTH-1:0]   right_ff, right_in;
   logic [POS_WIDTH-1:0]   bottom_ff, bottom_in;

   logic [POS_WIDTH-1:0]   last_column;
   logic [POS_WIDTH-1:0]   last_row;
   logic                   row_end;
   logic                   frame_end;
   logic                   nonzero;
   logic [TALLY_WIDTH-1:0] zero_upd, dim_upd, mid_upd, bright_upd;
   logic [CHAN_WIDTH-1:0]  peak_upd;
   logic                   seen_upd;
   logic [POS_WIDTH-1:0]   left_upd, top_upd, right_upd, bottom_upd;

   // Row and frame end against the clamped dimensions
   assign last_column = limit_last(frame_width);
   assign last_row    = limit_last(frame_height);
   assign row_end     = column_ff >= last_column;
   assign frame_end   = row_end && (row_ff >= last_row);
   assign nonzero     = info.pclass != CLASS_ZERO;

   // Statistics with this pixel included
   always_comb begin
      zero_upd   = sat_bump(zero_ff,   info.pclass == CLASS_ZERO);
      dim_upd    = sat_bump(dim_ff,    info.pclass == CLASS_DIM);
      mid_upd    = sat_bump(mid_ff,    info.pclass == CLASS_MID);
      bright_upd = sat_bump(bright_ff, info.pclass == CLASS_BRIGHT);
      peak_upd   = (nonzero && (info.peak > peak_ff)) ? info.peak : peak_ff;
      seen_upd   = seen_ff | nonzero;
      left_upd   = left_ff;
      top_upd    = top_ff;
      right_upd  = right_ff;
      bottom_upd = bottom_ff;
      if (nonzero) begin
         if (!seen_ff) begin
            left_upd   = column_ff;
            right_upd  = column_ff;
            top_upd    = row_ff;
            bottom_upd = row_ff;
         end else begin
            if (column_ff < left_ff) begin
               left_upd = column_ff;
            end
            if (column_ff > right_ff) begin
               right_upd = column_ff;
            end
            if (row_ff < top_ff) begin
               top_upd = row_ff;
            end
            if (row_ff > bottom_ff) begin
               bottom_upd = row_ff;
            end
         end
      end
   end

   // Result word; the box reads as zero until a nonzero pixel arrives
   always_comb begin
      result.frame_done   = frame_end;
      result.zero_count   = zero_upd;
      result.dim_count    = dim_upd;
      result.mid_count    = mid_upd;
      result.bright_count = bright_upd;
      result.peak_channel = peak_upd;
      result.any_nonzero  = seen_upd;
      result.box_left     = seen_upd ? left_upd   : '0;
      result.box_top      = seen_upd ? top_upd    : '0;
      result.box_right    = seen_upd ? right_upd  : '0;
      result.box_bottom   = seen_upd ? bottom_upd : '0;
   end

   // Advance the state: hold when idle, clear at frame end
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      zero_in   = zero_ff;
      dim_in    = dim_ff;
      mid_in    = mid_ff;
      bright_in = bright_ff;
      peak_in   = peak_ff;
      seen_in   = seen_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      if (step) begin
         if (frame_end) begin
            column_in = '0;
            row_in    = '0;
            zero_in   = '0;
            dim_in    = '0;
            mid_in    = '0;
            bright_in = '0;
            peak_in   = '0;
            seen_in   = 1'b0;
            left_in   = EDGE_ONES;
            top_in    = EDGE_ONES;
            right_in  = '0;
            bottom_in = '0;
         end else begin
            zero_in   = zero_upd;
            dim_in    = dim_upd;
            mid_in    = mid_upd;
            bright_in = bright_upd;
            peak_in   = peak_upd;
            seen_in   = seen_upd;
            left_in   = left_upd;
            top_in    = top_upd;
            right_in  = right_upd;
            bottom_in = bottom_upd;
            if (row_end) begin
               column_in = '0;
               row_in    = row_ff + 12'd1;
            end else begin
               column_in = column_ff + 12'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         zero_ff   <= '0;
         dim_ff    <= '0;
         mid_ff    <= '0;
         bright_ff <= '0;
         peak_ff   <= '0;
         seen_ff   <= 1'b0;
         left_ff   <= EDGE_ONES;
         top_ff    <= EDGE_ONES;
         right_ff  <= '0;
         bottom_ff <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         zero_ff   <= zero_in;
         dim_ff    <= dim_in;
         mid_ff    <= mid_in;
         bright_ff <= bright_in;
         peak_ff   <= peak_in;
         seen_ff   <= seen_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
      end
   end

endmodule

[rtl/core/pixel_convert_brightness_stats_core.sv]
// Pixel convert and statistics core: a word enters the input register, is then converted,
// classed and folded into the frame statistics, and loads the result register once it is free.
// Throughput: one word per clock while the result is taken; a full result register stalls
// the input register, and the statistics update between the two registers is combinational.
// Reset (synchronous): ARGB8888, 640 x 480, statistics and position reset, both valid flags cleared.
// Depends on pcbs_pkg, pcbs_convert, pcbs_stats and the defines header.
`include "pixel_convert_brightness_stats_core_defines.svh"

module pixel_convert_brightness_stats_core
   import pcbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [WORD_WIDTH-1:0]     req_pixel_word,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RGB_WIDTH-1:0]      rsp_rgb_out,
   output logic                      rsp_frame_done,
   output logic [TALLY_WIDTH-1:0]    rsp_zero_count,
   output logic [TALLY_WIDTH-1:0]    rsp_dim_count,
   output logic [TALLY_WIDTH-1:0]    rsp_mid_count,
   output logic [TALLY_WIDTH-1:0]    rsp_bright_count,
   output logic [CHAN_WIDTH-1:0]     rsp_peak_channel,
   output logic                      rsp_any_nonzero,
   output logic [POS_WIDTH-1:0]      rsp_box_left,
   output logic [POS_WIDTH-1:0]      rsp_box_top,
   output logic [POS_WIDTH-1:0]      rsp_box_right,
   output logic [POS_WIDTH-1:0]      rsp_box_bottom,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic                      format_ff, format_in;
   logic [DIM_WIDTH-1:0]      width_ff, width_in;
   logic [DIM_WIDTH-1:0]      height_ff, height_in;
   logic                      csr_write;
   csr_index_type             csr_index;

   logic                      s1_valid_ff, s1_valid_in;
   logic [WORD_WIDTH-1:0]     s1_word_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RGB_WIDTH-1:0]      rsp_rgb_ff;
   frame_stats_type           rsp_stats_ff;

   logic                      advance;
   logic                      step;
   pixel_info_type            info;
   frame_stats_type           stats;

   // Register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);

   always_comb begin
      format_in = format_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: format_in = pwdata[0];
            CSR_FRAME_WIDTH:  width_in  = pwdata[DIM_WIDTH-1:0];
            CSR_FRAME_HEIGHT: height_in = pwdata[DIM_WIDTH-1:0];
            default:          format_in = format_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_PIXEL_FORMAT: prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, format_ff};
         CSR_FRAME_WIDTH:  prdata = {{(CSR_DATA_WIDTH-DIM_WIDTH){1'b0}}, width_ff};
         CSR_FRAME_HEIGHT: prdata = {{(CSR_DATA_WIDTH-DIM_WIDTH){1'b0}}, height_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= 1'b0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         format_ff <= format_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Flow control: the result register frees up when empty or taken
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || advance;
   assign step        = s1_valid_ff && advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_word_ff <= req_pixel_word;
      end
   end

   pcbs_convert u_convert (
      .pixel_format (format_ff),
      .pixel_word   (s1_word_ff),
      .info         (info)
   );

   pcbs_stats u_stats (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .info         (info),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .result       (stats)
   );

   // Load the result word
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_rgb_ff   <= info.rgb;
         rsp_stats_ff <= stats;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rgb_out      = rsp_rgb_ff;
   assign rsp_frame_done   = rsp_stats_ff.frame_done;
   assign rsp_zero_count   = rsp_stats_ff.zero_count;
   assign rsp_dim_count    = rsp_stats_ff.dim_count;
   assign rsp_mid_count    = rsp_stats_ff.mid_count;
   assign rsp_bright_count = rsp_stats_ff.bright_count;
   assign rsp_peak_channel = rsp_stats_ff.peak_channel;
   assign rsp_any_nonzero  = rsp_stats_ff.any_nonzero;
   assign rsp_box_left     = rsp_stats_ff.box_left;
   assign rsp_box_top      = rsp_stats_ff.box_top;
   assign rsp_box_right    = rsp_stats_ff.box_right;
   assign rsp_box_bottom   = rsp_stats_ff.box_bottom;

   // Checks
   `PCBS_ASSERT_IMP(a_dark_frame, clock, reset, rsp_valid_ff && !rsp_stats_ff.any_nonzero, rsp_stats_ff.peak_channel == '0 && rsp_stats_ff.dim_count == '0 && rsp_stats_ff.mid_count == '0 && rsp_stats_ff.bright_count == '0, "statistics report lit pixels with none seen")
   `PCBS_ASSERT_IMP(a_peak_lit, clock, reset, rsp_valid_ff && rsp_stats_ff.any_nonzero, rsp_stats_ff.peak_channel != '0, "nonzero pixel seen but peak is zero")
   `PCBS_ASSERT_IMP(a_box_order, clock, reset, rsp_valid_ff && rsp_stats_ff.any_nonzero, rsp_stats_ff.box_left <= rsp_stats_ff.box_right && rsp_stats_ff.box_top <= rsp_stats_ff.box_bottom, "bounding box edges out of order")
   `PCBS_ASSERT_NXT(a_input_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_word_ff), "input word lost while result stalled")

endmodule
